### sv/geq_pkg.sv
// shared types, constants and fixed-point helpers of the graphic equalizer
package geq_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 24;
   localparam int DLY_W    = 32;
   localparam int PROD_W   = DLY_W + COEF_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int FRAC_W   = 21;
   localparam int RND_W    = ACC_W - FRAC_W + 1;

   localparam logic [3:0] ACTIVE_BANDS_RST  = 4'd10;
   localparam logic [3:0] CHANNEL_COUNT_RST = 4'd2;

   // band-pass feedback constant, -1.0050 in q3.21
   localparam logic signed [COEF_W-1:0] MA_COEF = -24'sd2107638;

   localparam logic [ACC_W:0] ROUND_HALF =
      {{(ACC_W - FRAC_W + 1){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};

   localparam logic signed [DLY_W-1:0] MIN32 = {1'b1, {(DLY_W - 1){1'b0}}};
   localparam logic signed [DLY_W-1:0] MAX32 = {1'b0, {(DLY_W - 1){1'b1}}};

   typedef enum logic {
      OP_FILTER = 1'b0,
      OP_WRITE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      COEF_A0   = 2'd0,
      COEF_A1   = 2'd1,
      COEF_B0   = 2'd2,
      COEF_GAIN = 2'd3
   } coef_sel_type;

   typedef enum logic [1:0] {
      CSR_ACTIVE_BANDS  = 2'd0,
      CSR_CHANNEL_COUNT = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef struct packed {
      logic       mul_en;
      acc_op_type acc_op;
      logic       rnd_prod;
   } mac_ctrl_type;

   // round to q.23 (add half, floor), full width, no saturation
   function automatic logic signed [RND_W-1:0] round_q23(
      input logic signed [ACC_W-1:0] v);
      logic [ACC_W:0] t;
      t = {v[ACC_W-1], v} + ROUND_HALF;
      round_q23 = t[ACC_W:FRAC_W];
   endfunction

   // saturate a full-width rounded value to 32 bits
   function automatic logic signed [DLY_W-1:0] sat32(
      input logic signed [RND_W-1:0] s);
      if (s[RND_W-1:DLY_W-1] == {(RND_W - DLY_W + 1){s[DLY_W-1]}}) begin
         sat32 = s[DLY_W-1:0];
      end else if (s[RND_W-1]) begin
         sat32 = MIN32;
      end else begin
         sat32 = MAX32;
      end
   endfunction

   function automatic logic signed [DLY_W-1:0] add_sat32(
      input logic signed [DLY_W-1:0] a,
      input logic signed [DLY_W-1:0] b);
      logic [DLY_W:0] s;
      s = {a[DLY_W-1], a} + {b[DLY_W-1], b};
      if (s[DLY_W] == s[DLY_W-1]) begin
         add_sat32 = s[DLY_W-1:0];
      end else if (s[DLY_W]) begin
         add_sat32 = MIN32;
      end else begin
         add_sat32 = MAX32;
      end
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat24(
      input logic signed [DLY_W-1:0] v);
      if (v[DLY_W-1:SAMPLE_W-1] == {(DLY_W - SAMPLE_W + 1){v[SAMPLE_W-1]}}) begin
         sat24 = v[SAMPLE_W-1:0];
      end else if (v[DLY_W-1]) begin
         sat24 = {1'b1, {(SAMPLE_W - 1){1'b0}}};
      end else begin
         sat24 = {1'b0, {(SAMPLE_W - 1){1'b1}}};
      end
   endfunction

endpackage

### sv/geq_ram.sv
// generic single-write, single-read ram with registered read data
module geq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/geq_mac.sv
// shared multiply-accumulate unit with q.23 rounding and saturation
module geq_mac (
   input  logic                                clock,
   input  geq_pkg::mac_ctrl_type               ctrl,
   input  logic signed [geq_pkg::DLY_W-1:0]    op_a,
   input  logic signed [geq_pkg::COEF_W-1:0]   op_b,
   output logic signed [geq_pkg::DLY_W-1:0]    rnd,
   output logic signed [geq_pkg::RND_W-1:0]    rnd_full
);

   logic signed [geq_pkg::PROD_W-1:0] mul;
   logic signed [geq_pkg::PROD_W-1:0] prod_ff;
   logic signed [geq_pkg::PROD_W-1:0] prod_in;
   logic signed [geq_pkg::ACC_W-1:0]  acc_ff;
   logic signed [geq_pkg::ACC_W-1:0]  acc_in;
   logic signed [geq_pkg::ACC_W-1:0]  rnd_src;

   assign mul = op_a * op_b;

   always_comb begin
      prod_in = ctrl.mul_en ? mul : prod_ff;
      unique case (ctrl.acc_op)
         geq_pkg::ACC_HOLD: acc_in = acc_ff;
         geq_pkg::ACC_LOAD: acc_in = geq_pkg::ACC_W'(prod_ff);
         geq_pkg::ACC_ADD:  acc_in = acc_ff + geq_pkg::ACC_W'(prod_ff);
         default:           acc_in = acc_ff;
      endcase
      rnd_src  = ctrl.rnd_prod ? geq_pkg::ACC_W'(prod_ff) : acc_ff;
      rnd_full = geq_pkg::round_q23(rnd_src);
      rnd      = geq_pkg::sat32(rnd_full);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

### sv/graphic_equalizer_iir_cascade.sv
// top level: multichannel graphic equalizer, band sections on one shared mac
// a taken sample runs through nb band sections in turn, then its result shows on rsp,
//   nb = min(active_bands, MAX_BANDS); each section steps the mac from ST_MUL_B0 to ST_Y
// a new sample is taken only once the last result is handed to rsp (req_stall till then);
//   coefficient/gain writes and samples of unused channels are taken without a filter pass
// reset: synchronous; clears the valid bits, so delay, coefficient and gain
//   stores read as zero until written; no clearing pass is needed
module graphic_equalizer_iir_cascade #(
   parameter int MAX_BANDS    = 10,
   parameter int MAX_CHANNELS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample / write requests
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_op,
   input  logic [2:0]                             req_channel,
   input  logic signed [geq_pkg::SAMPLE_W-1:0]    req_sample_in,
   input  logic [3:0]                             req_band,
   input  logic [1:0]                             req_coef_select,
   input  logic signed [geq_pkg::COEF_W-1:0]      req_coef_value,
   // equalized samples
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [geq_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   output logic [2:0]                             rsp_out_channel,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [3:0]                             csr_wdata
);

   localparam int ROWS = MAX_CHANNELS * MAX_BANDS;
   localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int BAW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int CNTW = $clog2(MAX_BANDS + 1);
   localparam int DW   = geq_pkg::DLY_W;
   localparam int CW   = geq_pkg::COEF_W;
   localparam int RW   = geq_pkg::RND_W;

   // one band section is walked through these states, one mac step each
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_B0,   // x * b0
      ST_MUL_A0,   // d1 * a0
      ST_MUL_A1,   // d2 * a1
      ST_MUL_C,    // d2 * feedback constant
      ST_W,        // w = round(sum)
      ST_TERM,     // term = w + round(d2 * c), delay shift written back
      ST_GAIN,     // term * gain, prefetch next band
      ST_Y,        // y += round(term * gain)
      ST_DONE      // hand result to output register
   } state_type;

   // row of a (channel, band) pair in the delay and gain stores
   function automatic logic [RAW-1:0] row_of(input int unsigned ch, input int unsigned b);
      row_of = RAW'(ch * MAX_BANDS + b);
   endfunction

   state_type                state_ff, state_in;
   logic [BAW-1:0]           k_ff, k_in;
   logic [CNTW-1:0]          nb_ff, nb_in;
   logic [2:0]               ch_ff, ch_in;
   logic signed [DW-1:0]     y_ff, y_in;
   logic signed [DW-1:0]     w_ff, w_in;
   logic signed [DW-1:0]     term_ff, term_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [geq_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [2:0]               rsp_ch_ff, rsp_ch_in;
   logic [3:0]               active_ff, active_in;
   logic [3:0]               chcnt_ff, chcnt_in;

   // valid bits: an entry never written reads as zero
   logic [MAX_BANDS-1:0]     a0_vld_ff, a0_vld_in;
   logic [MAX_BANDS-1:0]     a1_vld_ff, a1_vld_in;
   logic [MAX_BANDS-1:0]     b0_vld_ff, b0_vld_in;
   logic [ROWS-1:0]          gain_vld_ff, gain_vld_in;
   logic [ROWS-1:0]          dly_vld_ff, dly_vld_in;
   // valid bits captured along with the registered read data
   logic                     a0_vq_ff, a0_vq_in;
   logic                     a1_vq_ff, a1_vq_in;
   logic                     b0_vq_ff, b0_vq_in;
   logic                     gain_vq_ff, gain_vq_in;
   logic                     dly_vq_ff, dly_vq_in;

   logic                     req_accept;
   logic                     ch_ok;
   logic                     band_ok;
   logic                     sample_go;
   logic                     out_free;
   logic                     last;
   logic [CNTW-1:0]          kp1;
   logic [CNTW-1:0]          nb_cfg;

   logic                     rd_en;
   logic [BAW-1:0]           rd_band;
   logic [2:0]               rd_ch;
   logic [RAW-1:0]           rd_row;

   logic                     a0_we, a1_we, b0_we, gain_we, dly_we;
   logic [BAW-1:0]           coef_waddr;
   logic [RAW-1:0]           gain_waddr;
   logic [RAW-1:0]           dly_waddr;

   logic [CW-1:0]            a0_rd, a1_rd, b0_rd, gain_rd;
   logic [2*DW-1:0]          dly_rd;
   logic signed [CW-1:0]     a0_q, a1_q, b0_q, gain_q;
   logic signed [DW-1:0]     d1_q, d2_q;

   geq_pkg::mac_ctrl_type    mac_ctrl;
   logic signed [DW-1:0]     mac_a;
   logic signed [CW-1:0]     mac_b;
   logic signed [DW-1:0]     mac_rnd;
   logic signed [RW-1:0]     mac_rnd_full;

   // ---------------------------------------------------------------- decode
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign band_ok    = 32'(req_band) < MAX_BANDS;
   // channel must be below both the configured count and the built maximum
   assign ch_ok      = (32'(req_channel) < 32'(chcnt_ff))
                    && (32'(req_channel) < MAX_CHANNELS);
   assign sample_go  = req_accept && (req_op == geq_pkg::OP_FILTER) && ch_ok;
   assign kp1        = CNTW'(k_ff) + CNTW'(1);
   assign last       = kp1 >= nb_ff;

   always_comb begin
      if (32'(active_ff) > MAX_BANDS) begin
         nb_cfg = CNTW'(MAX_BANDS);
      end else begin
         nb_cfg = CNTW'(active_ff);
      end
   end

   // ---------------------------------------------------------------- stores
   // coefficient and gain writes land straight from the request
   assign coef_waddr = BAW'(req_band);
   assign gain_waddr = row_of(32'(req_channel), 32'(req_band));
   assign a0_we   = req_accept && (req_op == geq_pkg::OP_WRITE) && band_ok
                 && (req_coef_select == geq_pkg::COEF_A0);
   assign a1_we   = req_accept && (req_op == geq_pkg::OP_WRITE) && band_ok
                 && (req_coef_select == geq_pkg::COEF_A1);
   assign b0_we   = req_accept && (req_op == geq_pkg::OP_WRITE) && band_ok
                 && (req_coef_select == geq_pkg::COEF_B0);
   assign gain_we = req_accept && (req_op == geq_pkg::OP_WRITE) && band_ok
                 && (req_coef_select == geq_pkg::COEF_GAIN)
                 && (32'(req_channel) < MAX_CHANNELS);

   // delay pair shifts once per section: d1 <= w, d2 <= d1
   assign dly_we    = (state_ff == ST_TERM);
   assign dly_waddr = row_of(32'(ch_ff), 32'(k_ff));

   // band 0 is fetched as the sample is taken, band k+1 during the gain step
   assign rd_en   = (state_ff == ST_IDLE) ? (sample_go && (nb_cfg != '0))
                                          : ((state_ff == ST_GAIN) && !last);
   assign rd_band = (state_ff == ST_IDLE) ? '0 : BAW'(kp1);
   assign rd_ch   = (state_ff == ST_IDLE) ? req_channel : ch_ff;
   assign rd_row  = row_of(32'(rd_ch), 32'(rd_band));

   geq_ram #(.WIDTH(CW), .DEPTH(MAX_BANDS)) u_a0_ram (
      .clock   (clock),
      .wr_en   (a0_we),
      .wr_addr (coef_waddr),
      .wr_data (req_coef_value),
      .rd_en   (rd_en),
      .rd_addr (rd_band),
      .rd_data (a0_rd)
   );

   geq_ram #(.WIDTH(CW), .DEPTH(MAX_BANDS)) u_a1_ram (
      .clock   (clock),
      .wr_en   (a1_we),
      .wr_addr (coef_waddr),
      .wr_data (req_coef_value),
      .rd_en   (rd_en),
      .rd_addr (rd_band),
      .rd_data (a1_rd)
   );

   geq_ram #(.WIDTH(CW), .DEPTH(MAX_BANDS)) u_b0_ram (
      .clock   (clock),
      .wr_en   (b0_we),
      .wr_addr (coef_waddr),
      .wr_data (req_coef_value),
      .rd_en   (rd_en),
      .rd_addr (rd_band),
      .rd_data (b0_rd)
   );

   geq_ram #(.WIDTH(CW), .DEPTH(ROWS)) u_gain_ram (
      .clock   (clock),
      .wr_en   (gain_we),
      .wr_addr (gain_waddr),
      .wr_data (req_coef_value),
      .rd_en   (rd_en),
      .rd_addr (rd_row),
      .rd_data (gain_rd)
   );

   // one row holds the delay pair {d1, d2} of a channel and band
   geq_ram #(.WIDTH(2 * DW), .DEPTH(ROWS)) u_dly_ram (
      .clock   (clock),
      .wr_en   (dly_we),
      .wr_addr (dly_waddr),
      .wr_data ({w_ff, d1_q}),
      .rd_en   (rd_en),
      .rd_addr (rd_row),
      .rd_data (dly_rd)
   );

   assign a0_q   = a0_vq_ff   ? a0_rd   : '0;
   assign a1_q   = a1_vq_ff   ? a1_rd   : '0;
   assign b0_q   = b0_vq_ff   ? b0_rd   : '0;
   assign gain_q = gain_vq_ff ? gain_rd : '0;
   assign d1_q   = dly_vq_ff  ? dly_rd[2*DW-1:DW] : '0;
   assign d2_q   = dly_vq_ff  ? dly_rd[DW-1:0]    : '0;

   // ---------------------------------------------------------------- mac
   // operand select and mac sequencing per state
   always_comb begin
      mac_ctrl.mul_en   = 1'b0;
      mac_ctrl.acc_op   = geq_pkg::ACC_HOLD;
      mac_ctrl.rnd_prod = 1'b0;
      mac_a             = '0;
      mac_b             = '0;
      unique case (state_ff)
         ST_MUL_B0: begin
            mac_ctrl.mul_en = 1'b1;
            mac_a           = y_ff;
            mac_b           = b0_q;
         end
         ST_MUL_A0: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = geq_pkg::ACC_LOAD;
            mac_a           = d1_q;
            mac_b           = a0_q;
         end
         ST_MUL_A1: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = geq_pkg::ACC_ADD;
            mac_a           = d2_q;
            mac_b           = a1_q;
         end
         ST_MUL_C: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = geq_pkg::ACC_ADD;
            mac_a           = d2_q;
            mac_b           = geq_pkg::MA_COEF;
         end
         ST_TERM: begin
            // product register still holds d2 * c here
            mac_ctrl.rnd_prod = 1'b1;
         end
         ST_GAIN: begin
            mac_ctrl.mul_en = 1'b1;
            mac_a           = term_ff;
            mac_b           = gain_q;
         end
         ST_Y: begin
            mac_ctrl.rnd_prod = 1'b1;
         end
         default: begin
         end
      endcase
   end

   geq_mac u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .op_a     (mac_a),
      .op_b     (mac_b),
      .rnd      (mac_rnd),
      .rnd_full (mac_rnd_full)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      nb_in         = nb_ff;
      ch_in         = ch_ff;
      y_in          = y_ff;
      w_in          = w_ff;
      term_in       = term_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_ch_in     = rsp_ch_ff;
      active_in     = active_ff;
      chcnt_in      = chcnt_ff;

      a0_vld_in   = a0_vld_ff;
      a1_vld_in   = a1_vld_ff;
      b0_vld_in   = b0_vld_ff;
      gain_vld_in = gain_vld_ff;
      dly_vld_in  = dly_vld_ff;
      if (a0_we)   a0_vld_in[coef_waddr]   = 1'b1;
      if (a1_we)   a1_vld_in[coef_waddr]   = 1'b1;
      if (b0_we)   b0_vld_in[coef_waddr]   = 1'b1;
      if (gain_we) gain_vld_in[gain_waddr] = 1'b1;
      if (dly_we)  dly_vld_in[dly_waddr]   = 1'b1;

      a0_vq_in   = a0_vq_ff;
      a1_vq_in   = a1_vq_ff;
      b0_vq_in   = b0_vq_ff;
      gain_vq_in = gain_vq_ff;
      dly_vq_in  = dly_vq_ff;
      if (rd_en) begin
         a0_vq_in   = a0_vld_ff[rd_band];
         a1_vq_in   = a1_vld_ff[rd_band];
         b0_vq_in   = b0_vld_ff[rd_band];
         gain_vq_in = gain_vld_ff[rd_row];
         dly_vq_in  = dly_vld_ff[rd_row];
      end

      if (csr_valid) begin
         unique case (csr_index)
            geq_pkg::CSR_ACTIVE_BANDS:  active_in = csr_wdata;
            geq_pkg::CSR_CHANNEL_COUNT: chcnt_in  = csr_wdata;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (sample_go) begin
               ch_in = req_channel;
               y_in  = DW'(req_sample_in);
               k_in  = '0;
               nb_in = nb_cfg;
               // zero active bands passes the sample straight through
               state_in = (nb_cfg == '0) ? ST_DONE : ST_MUL_B0;
            end
         end
         ST_MUL_B0: state_in = ST_MUL_A0;
         ST_MUL_A0: state_in = ST_MUL_A1;
         ST_MUL_A1: state_in = ST_MUL_C;
         ST_MUL_C:  state_in = ST_W;
         ST_W: begin
            w_in     = mac_rnd;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            // rounded d2 * c can exceed 32 bits, only the sum saturates
            term_in  = geq_pkg::sat32(RW'(w_ff) + mac_rnd_full);
            state_in = ST_GAIN;
         end
         ST_GAIN: state_in = ST_Y;
         ST_Y: begin
            y_in = geq_pkg::add_sat32(y_ff, mac_rnd);
            if (last) begin
               state_in = ST_DONE;
            end else begin
               k_in     = BAW'(kp1);
               state_in = ST_MUL_B0;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = geq_pkg::sat24(y_ff);
               rsp_ch_in     = ch_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         nb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= geq_pkg::ACTIVE_BANDS_RST;
         chcnt_ff     <= geq_pkg::CHANNEL_COUNT_RST;
         a0_vld_ff    <= '0;
         a1_vld_ff    <= '0;
         b0_vld_ff    <= '0;
         gain_vld_ff  <= '0;
         dly_vld_ff   <= '0;
         a0_vq_ff     <= 1'b0;
         a1_vq_ff     <= 1'b0;
         b0_vq_ff     <= 1'b0;
         gain_vq_ff   <= 1'b0;
         dly_vq_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         nb_ff        <= nb_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         chcnt_ff     <= chcnt_in;
         a0_vld_ff    <= a0_vld_in;
         a1_vld_ff    <= a1_vld_in;
         b0_vld_ff    <= b0_vld_in;
         gain_vld_ff  <= gain_vld_in;
         dly_vld_ff   <= dly_vld_in;
         a0_vq_ff     <= a0_vq_in;
         a1_vq_ff     <= a1_vq_in;
         b0_vq_ff     <= b0_vq_in;
         gain_vq_ff   <= gain_vq_in;
         dly_vq_ff    <= dly_vq_in;
      end
      ch_ff         <= ch_in;
      y_ff          <= y_in;
      w_ff          <= w_in;
      term_ff       <= term_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_ch_ff     <= rsp_ch_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_out_channel = rsp_ch_ff;

   // ---------------------------------------------------------------- checks
   // band counter stays inside the cascade while a section runs
   a_band_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_DONE) |-> (CNTW'(k_ff) < nb_ff))
      else $error("band counter past active band count");

   // a result only appears out of the hand-off state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside hand-off state");

   // coefficient and gain writes never start the filter sequence
   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op == geq_pkg::OP_WRITE) |=> (state_ff == ST_IDLE))
      else $error("write request started a filter pass");

endmodule
